// ===== rtl/core/two_channel_phase_amplitude_meter_assert.svh =====
// Assertion macros used by the phase and amplitude meter result engine (tcpam_calc).
`ifndef TWO_CHANNEL_PHASE_AMPLITUDE_METER_ASSERT_SVH
`define TWO_CHANNEL_PHASE_AMPLITUDE_METER_ASSERT_SVH
`ifndef ASSERT_OFF
// checked only while out of reset
`define TCPAM_CHECK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tcpam check failed");
// checked at every edge, reset included
`define TCPAM_CHECK_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tcpam check failed");
`else
`define TCPAM_CHECK(lbl, clk, rstn, prop)
`define TCPAM_CHECK_ALL(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/tcpam_pkg.sv =====
// Shared constants and types of the phase and amplitude meter.
`default_nettype none
package tcpam_pkg;
    localparam int COUNT_BITS_DEF = 32;
    localparam int SAMPLE_BITS    = 10;
    localparam int TICK_BITS      = 16;
    localparam int RATE_BITS      = 27;
    localparam int VREF_BITS      = 13;
    localparam int WIDE_BITS      = 33;
    localparam int RMS_BITS       = 12;
    localparam int PHASE_BITS     = 16;

    localparam int LOW_RESET      = 2;
    localparam int HIGH_RESET     = 4;
    localparam int RATE_RESET     = 22118400;
    localparam int VREF_RESET     = 4096;

    // full scale 1023 times 1414 (sqrt 2 scaled by 1000)
    localparam int RMS_DEN        = ((1 << SAMPLE_BITS) - 1) * 1414;
    localparam int MV_SCALE       = 1000;
    localparam int PHASE_SCALE    = 18000;
    localparam int FREQ_SCALE     = 50;
    localparam int PHASE_CLAMP    = 35999;
    localparam int PHASE_HALF     = 18000;
    localparam int PHASE_FULL     = 36000;
    localparam int PHASE_BIG_NEG  = -2000;
    localparam int PHASE_ADJ_BIG  = 500;
    localparam int PHASE_ADJ_SML  = 300;
    localparam int RMS_MAX        = 4095;
    localparam int MUL_BW         = 15;

    localparam int APB_ADDR_BITS  = 4;
    localparam int APB_DATA_BITS  = 32;

    typedef enum logic [1:0] {
        REG_LOW_LEVEL  = 2'd0,
        REG_HIGH_LEVEL = 2'd1,
        REG_TIMER_RATE = 2'd2,
        REG_VREF       = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic fire;
        logic zero_half;
    } round_ev_t;
endpackage
`default_nettype wire

// ===== rtl/core/tcpam_ifs.sv =====
// Sample and result channel interfaces.
`default_nettype none
interface tcpam_in_if;
    import tcpam_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic [TICK_BITS-1:0]   elapsed_ticks;
    modport source (output valid, sample_a, sample_b, elapsed_ticks, input ready);
    modport sink (input valid, sample_a, sample_b, elapsed_ticks, output ready);
endinterface

interface tcpam_out_if;
    import tcpam_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [WIDE_BITS-1:0]         period_a_ticks;
    logic [WIDE_BITS-1:0]         period_b_ticks;
    logic [WIDE_BITS-1:0]         freq_a_centihz;
    logic [SAMPLE_BITS-1:0]       peak_a;
    logic [SAMPLE_BITS-1:0]       peak_b;
    logic [RMS_BITS-1:0]          rms_a_mv;
    logic [RMS_BITS-1:0]          rms_b_mv;
    logic signed [PHASE_BITS-1:0] phase_centideg;
    logic                         zero_period;
    modport source (output valid, period_a_ticks, period_b_ticks, freq_a_centihz, peak_a,
                    peak_b, rms_a_mv, rms_b_mv, phase_centideg, zero_period, input ready);
    modport sink (input valid, period_a_ticks, period_b_ticks, freq_a_centihz, peak_a,
                  peak_b, rms_a_mv, rms_b_mv, phase_centideg, zero_period, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tcpam_smul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module tcpam_smul #(
    parameter int AW = 47,
    parameter int BW = 15
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [AW-1:0] a,
    input  wire logic [BW-1:0] b,
    output logic               done,
    output logic [AW-1:0]      prod
);
    localparam int CW = $clog2(BW + 1);

    logic [AW-1:0] acc_reg;
    logic [AW-1:0] a_reg;
    logic [BW-1:0] b_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(BW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (run_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[AW-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

// ===== rtl/core/tcpam_sdiv.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tcpam_sdiv #(
    parameter int NW = 47,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;

    // partial remainder gets the next numerator bit; quotient fills num_reg from the bottom
    assign shifted = {rem_reg, num_reg[NW-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            num_reg <= {num_reg[NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = num_reg;
endmodule
`default_nettype wire

// ===== rtl/core/tcpam_seq.sv =====
// Crossing sequencer: tick counting, delay, half periods and channel A peak capture.
`default_nettype none
module tcpam_seq #(
    parameter int CNT_W = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             take,
    input  wire logic [tcpam_pkg::SAMPLE_BITS-1:0] sample_a,
    input  wire logic [tcpam_pkg::SAMPLE_BITS-1:0] sample_b,
    input  wire logic [tcpam_pkg::TICK_BITS-1:0]   elapsed,
    input  wire logic [tcpam_pkg::SAMPLE_BITS-1:0] low_level,
    input  wire logic [tcpam_pkg::SAMPLE_BITS-1:0] high_level,
    output logic [CNT_W-1:0]                      delay_ticks,
    output logic [CNT_W-1:0]                      half_a,
    output logic [CNT_W-1:0]                      half_b,
    output logic [tcpam_pkg::SAMPLE_BITS-1:0]      held_peak_a,
    output tcpam_pkg::round_ev_t                  ev
);
    import tcpam_pkg::*;

    localparam logic [3:0] ST_A_LOW_D  = 4'd0;
    localparam logic [3:0] ST_A_HIGH_D = 4'd1;
    localparam logic [3:0] ST_B_LOW_D  = 4'd2;
    localparam logic [3:0] ST_B_HIGH_D = 4'd3;
    localparam logic [3:0] ST_A_LOW_H  = 4'd4;
    localparam logic [3:0] ST_A_HIGH_H = 4'd5;
    localparam logic [3:0] ST_HALF_A   = 4'd6;
    localparam logic [3:0] ST_A_LOW_P  = 4'd7;
    localparam logic [3:0] ST_A_HIGH_P = 4'd8;
    localparam logic [3:0] ST_QUART_A  = 4'd9;
    localparam logic [3:0] ST_B_LOW_H  = 4'd10;
    localparam logic [3:0] ST_B_HIGH_H = 4'd11;
    localparam logic [3:0] ST_HALF_B   = 4'd12;
    localparam logic [3:0] ST_B_LOW_P  = 4'd13;
    localparam logic [3:0] ST_B_HIGH_P = 4'd14;
    localparam logic [3:0] ST_QUART_B  = 4'd15;

    logic [3:0]             step_reg,  step_next;
    logic [CNT_W-1:0]       tick_reg,  tick_next;
    logic [CNT_W-1:0]       delay_reg, delay_next;
    logic [CNT_W-1:0]       ha_reg,    ha_next;
    logic [CNT_W-1:0]       hb_reg,    hb_next;
    logic [SAMPLE_BITS-1:0] pk_reg,    pk_next;
    logic [CNT_W:0]         sum;
    logic [CNT_W-1:0]       cnt_add;
    logic                   a_low, a_high, b_low, b_high;
    logic                   quart_a, quart_b;
    logic                   fire;

    assign a_low   = sample_a <= low_level;
    assign a_high  = sample_a >= high_level;
    assign b_low   = sample_b <= low_level;
    assign b_high  = sample_b >= high_level;
    assign sum     = {1'b0, tick_reg} + (CNT_W + 1)'(elapsed);
    assign cnt_add = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    assign quart_a = {cnt_add, 1'b0} >= {1'b0, ha_reg};
    assign quart_b = {cnt_add, 1'b0} >= {1'b0, hb_reg};

    always_comb
    begin
        step_next  = step_reg;
        tick_next  = tick_reg;
        delay_next = delay_reg;
        ha_next    = ha_reg;
        hb_next    = hb_reg;
        pk_next    = pk_reg;
        fire       = 1'b0;
        if (take)
        begin
            case (step_reg)
                ST_A_LOW_D, ST_A_LOW_H, ST_A_LOW_P:
                begin
                    if (a_low) step_next = step_reg + 1'b1;
                end
                ST_A_HIGH_D, ST_A_HIGH_H, ST_A_HIGH_P:
                begin
                    if (a_high)
                    begin
                        tick_next = '0;
                        step_next = step_reg + 1'b1;
                    end
                end
                ST_B_LOW_D:
                begin
                    tick_next = cnt_add;
                    if (b_low) step_next = step_reg + 1'b1;
                end
                ST_B_HIGH_D:
                begin
                    tick_next = cnt_add;
                    if (b_high)
                    begin
                        delay_next = cnt_add;
                        step_next  = step_reg + 1'b1;
                    end
                end
                ST_HALF_A:
                begin
                    tick_next = cnt_add;
                    if (a_low)
                    begin
                        ha_next   = cnt_add;
                        step_next = step_reg + 1'b1;
                    end
                end
                ST_QUART_A:
                begin
                    tick_next = cnt_add;
                    if (quart_a)
                    begin
                        pk_next   = sample_a;
                        step_next = step_reg + 1'b1;
                    end
                end
                ST_B_LOW_H, ST_B_LOW_P:
                begin
                    if (b_low) step_next = step_reg + 1'b1;
                end
                ST_B_HIGH_H, ST_B_HIGH_P:
                begin
                    if (b_high)
                    begin
                        tick_next = '0;
                        step_next = step_reg + 1'b1;
                    end
                end
                ST_HALF_B:
                begin
                    tick_next = cnt_add;
                    if (b_low)
                    begin
                        hb_next   = cnt_add;
                        step_next = step_reg + 1'b1;
                    end
                end
                ST_QUART_B:
                begin
                    tick_next = cnt_add;
                    if (quart_b)
                    begin
                        fire      = 1'b1;
                        step_next = ST_A_LOW_D;
                    end
                end
                default:
                begin
                    step_next = ST_A_LOW_D;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_A_LOW_D;
            tick_reg  <= '0;
            delay_reg <= '0;
            ha_reg    <= '0;
            hb_reg    <= '0;
            pk_reg    <= '0;
        end
        else
        begin
            step_reg  <= step_next;
            tick_reg  <= tick_next;
            delay_reg <= delay_next;
            ha_reg    <= ha_next;
            hb_reg    <= hb_next;
            pk_reg    <= pk_next;
        end
    end

    assign delay_ticks  = delay_reg;
    assign half_a       = ha_reg;
    assign half_b       = hb_reg;
    assign held_peak_a  = pk_reg;
    assign ev.fire      = fire;
    assign ev.zero_half = ha_reg == '0;
endmodule
`default_nettype wire

// ===== rtl/core/tcpam_calc.sv =====
// Round-end engine: serial multiplies and divides, then the result word.
`default_nettype none
`include "two_channel_phase_amplitude_meter_assert.svh"
module tcpam_calc #(
    parameter int CNT_W = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  tcpam_pkg::round_ev_t                  ev,
    input  wire logic [CNT_W-1:0]                 delay_ticks,
    input  wire logic [CNT_W-1:0]                 half_a,
    input  wire logic [CNT_W-1:0]                 half_b,
    input  wire logic [tcpam_pkg::SAMPLE_BITS-1:0] peak_a,
    input  wire logic [tcpam_pkg::SAMPLE_BITS-1:0] peak_b,
    input  wire logic [tcpam_pkg::RATE_BITS-1:0]   timer_rate_hz,
    input  wire logic [tcpam_pkg::VREF_BITS-1:0]   vref_mv,
    output logic                                  busy,
    tcpam_out_if.source                           res
);
    import tcpam_pkg::*;

    localparam int NUM_W = (CNT_W + 15 > 34) ? CNT_W + 15 : 34;
    localparam int DEN_W = (CNT_W > 21) ? CNT_W : 21;
    localparam int PER_W = (CNT_W + 1 > 34) ? CNT_W + 1 : 34;

    typedef enum logic [3:0] {
        C_IDLE   = 4'b0001,
        C_LAUNCH = 4'b0010,
        C_RUN    = 4'b0100,
        C_HOLD   = 4'b1000
    } cstate_t;

    typedef enum logic [3:0] {
        J_PH_MUL = 4'd0,
        J_PH_DIV = 4'd1,
        J_FR_MUL = 4'd2,
        J_FR_DIV = 4'd3,
        J_RA_MUL = 4'd4,
        J_RA_SCL = 4'd5,
        J_RA_DIV = 4'd6,
        J_RB_MUL = 4'd7,
        J_RB_SCL = 4'd8,
        J_RB_DIV = 4'd9
    } job_t;

    cstate_t                state_reg;
    job_t                   job_reg;
    logic [CNT_W-1:0]       delay_reg, ha_reg, hb_reg;
    logic [SAMPLE_BITS-1:0] pa_reg, pb_reg;
    logic                   zero_reg;
    logic signed [PHASE_BITS-1:0] phase_reg;
    logic [WIDE_BITS-1:0]   freq_reg;
    logic [RMS_BITS-1:0]    rms_a_reg, rms_b_reg;

    logic                   out_valid_reg;
    logic [WIDE_BITS-1:0]   out_pa_reg, out_pb_reg, out_freq_reg;
    logic [SAMPLE_BITS-1:0] out_peak_a_reg, out_peak_b_reg;
    logic [RMS_BITS-1:0]    out_rms_a_reg, out_rms_b_reg;
    logic signed [PHASE_BITS-1:0] out_phase_reg;
    logic                   out_zero_reg;

    logic                   mul_start, div_start, mul_done, div_done;
    logic [NUM_W-1:0]       mul_a, mul_prod, div_quot;
    logic [MUL_BW-1:0]      mul_b;
    logic [DEN_W-1:0]       div_den;
    logic                   is_mul, out_load;
    logic [PHASE_BITS-1:0]  ph_mag;
    logic signed [PHASE_BITS:0] ph_wrap, ph_fix;
    logic [RMS_BITS-1:0]    rms_sat;
    logic [WIDE_BITS-1:0]   freq_sat;
    logic [PER_W-1:0]       per_a, per_b;

    always_comb
    begin
        is_mul  = 1'b0;
        mul_a   = mul_prod;
        mul_b   = MUL_BW'(MV_SCALE);
        div_den = DEN_W'(ha_reg);
        case (job_reg)
            J_PH_MUL:
            begin
                is_mul = 1'b1;
                mul_a  = NUM_W'(delay_reg);
                mul_b  = MUL_BW'(PHASE_SCALE);
            end
            J_FR_MUL:
            begin
                is_mul = 1'b1;
                mul_a  = NUM_W'(timer_rate_hz);
                mul_b  = MUL_BW'(FREQ_SCALE);
            end
            J_RA_MUL:
            begin
                is_mul = 1'b1;
                mul_a  = NUM_W'(pa_reg);
                mul_b  = MUL_BW'(vref_mv);
            end
            J_RB_MUL:
            begin
                is_mul = 1'b1;
                mul_a  = NUM_W'(pb_reg);
                mul_b  = MUL_BW'(vref_mv);
            end
            J_RA_SCL, J_RB_SCL:
            begin
                is_mul = 1'b1;
            end
            J_RA_DIV, J_RB_DIV:
            begin
                div_den = DEN_W'(RMS_DEN);
            end
            default:
            begin
                div_den = DEN_W'(ha_reg);
            end
        endcase
    end

    assign mul_start = (state_reg == C_LAUNCH) && is_mul;
    assign div_start = (state_reg == C_LAUNCH) && !is_mul;

    tcpam_smul #(.AW(NUM_W), .BW(MUL_BW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    tcpam_sdiv #(.NW(NUM_W), .DW(DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_prod),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // phase: clamp, wrap above half a turn, then the negative-side trims
    always_comb
    begin
        ph_mag = (div_quot > NUM_W'(PHASE_CLAMP)) ? PHASE_BITS'(PHASE_CLAMP)
                                                  : div_quot[PHASE_BITS-1:0];
        ph_wrap = $signed({1'b0, ph_mag}) - $signed((PHASE_BITS + 1)'(PHASE_FULL));
        ph_fix  = $signed({1'b0, ph_mag});
        if (ph_mag > PHASE_BITS'(PHASE_HALF))
        begin
            ph_fix = ph_wrap;
            if (ph_wrap < $signed((PHASE_BITS + 1)'(PHASE_BIG_NEG)))
            begin
                ph_fix = ph_wrap - $signed((PHASE_BITS + 1)'(PHASE_ADJ_BIG));
            end
            else if (ph_wrap > $signed((PHASE_BITS + 1)'(PHASE_BIG_NEG)) &&
                     ph_wrap < $signed((PHASE_BITS + 1)'(0)))
            begin
                ph_fix = ph_wrap - $signed((PHASE_BITS + 1)'(PHASE_ADJ_SML));
            end
        end
    end

    assign rms_sat  = (div_quot > NUM_W'(RMS_MAX)) ? RMS_BITS'(RMS_MAX)
                                                   : div_quot[RMS_BITS-1:0];
    assign freq_sat = (div_quot > NUM_W'({WIDE_BITS{1'b1}})) ? '1
                                                             : div_quot[WIDE_BITS-1:0];
    assign per_a    = PER_W'({ha_reg, 1'b0});
    assign per_b    = PER_W'({hb_reg, 1'b0});

    assign out_load = (state_reg == C_HOLD) && (!out_valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            job_reg       <= J_PH_MUL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                C_IDLE:
                begin
                    if (ev.fire)
                    begin
                        job_reg   <= J_PH_MUL;
                        state_reg <= C_LAUNCH;
                    end
                end
                C_LAUNCH:
                begin
                    state_reg <= C_RUN;
                end
                C_RUN:
                begin
                    if (mul_done || div_done)
                    begin
                        if (job_reg == J_RB_DIV)
                        begin
                            state_reg <= C_HOLD;
                        end
                        else
                        begin
                            job_reg   <= job_t'(job_reg + 1'b1);
                            state_reg <= C_LAUNCH;
                        end
                    end
                end
                C_HOLD:
                begin
                    if (out_load) state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev.fire && state_reg == C_IDLE)
        begin
            delay_reg <= delay_ticks;
            ha_reg    <= half_a;
            hb_reg    <= half_b;
            pa_reg    <= peak_a;
            pb_reg    <= peak_b;
            zero_reg  <= ev.zero_half;
        end
        if (state_reg == C_RUN && div_done)
        begin
            case (job_reg)
                J_PH_DIV: phase_reg <= ph_fix[PHASE_BITS-1:0];
                J_FR_DIV: freq_reg  <= freq_sat;
                J_RA_DIV: rms_a_reg <= rms_sat;
                J_RB_DIV: rms_b_reg <= rms_sat;
                default:  rms_b_reg <= rms_b_reg;
            endcase
        end
        if (out_load)
        begin
            out_pa_reg     <= (per_a > PER_W'({WIDE_BITS{1'b1}})) ? '1 : per_a[WIDE_BITS-1:0];
            out_pb_reg     <= (per_b > PER_W'({WIDE_BITS{1'b1}})) ? '1 : per_b[WIDE_BITS-1:0];
            out_freq_reg   <= zero_reg ? '0 : freq_reg;
            out_phase_reg  <= zero_reg ? '0 : phase_reg;
            out_peak_a_reg <= pa_reg;
            out_peak_b_reg <= pb_reg;
            out_rms_a_reg  <= rms_a_reg;
            out_rms_b_reg  <= rms_b_reg;
            out_zero_reg   <= zero_reg;
        end
    end

    assign busy               = state_reg != C_IDLE;
    assign res.valid          = out_valid_reg;
    assign res.period_a_ticks = out_pa_reg;
    assign res.period_b_ticks = out_pb_reg;
    assign res.freq_a_centihz = out_freq_reg;
    assign res.peak_a         = out_peak_a_reg;
    assign res.peak_b         = out_peak_b_reg;
    assign res.rms_a_mv       = out_rms_a_reg;
    assign res.rms_b_mv       = out_rms_b_reg;
    assign res.phase_centideg = out_phase_reg;
    assign res.zero_period    = out_zero_reg;

    `TCPAM_CHECK(a_fire_when_idle, clk, rst_n, ev.fire |-> state_reg == C_IDLE)
    `TCPAM_CHECK(a_one_unit_done, clk, rst_n, !(mul_done && div_done))
    `TCPAM_CHECK(a_no_overwrite, clk, rst_n, out_load |-> (!res.valid || res.ready))
    `TCPAM_CHECK(a_done_in_run, clk, rst_n, (mul_done || div_done) |-> state_reg == C_RUN)
    `TCPAM_CHECK_ALL(a_reset_idle, clk, !rst_n |=> state_reg == C_IDLE)
endmodule
`default_nettype wire

// ===== rtl/core/two_channel_phase_amplitude_meter.sv =====
// Two-channel phase and amplitude meter: top level with APB register file.
//
// Each sample word is taken while samples.ready is high and steps the crossing sequencer.
// When a word ends a measurement round, the result engine runs six serial
// multiplies and four serial divides with numerators of max(COUNT_BITS+15, 34)
// bits on one shared multiplier and one shared divider; samples.ready is low
// during that time and while a finished result still sits behind an unread one.
// Registers at byte addresses 0, 4, 8, 12: low_level, high_level, timer_rate_hz,
// vref_mv; write only while the block is idle.
`default_nettype none
module two_channel_phase_amplitude_meter #(
    parameter int COUNT_BITS = tcpam_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tcpam_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [tcpam_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [tcpam_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready,
    tcpam_in_if.sink                               samples,
    tcpam_out_if.source                            results
);
    import tcpam_pkg::*;

    logic [SAMPLE_BITS-1:0] low_reg, high_reg;
    logic [RATE_BITS-1:0]   rate_reg;
    logic [VREF_BITS-1:0]   vref_reg;
    reg_idx_t               idx;
    logic                   wr;
    logic                   busy, take;
    logic [COUNT_BITS-1:0]  delay_ticks, half_a, half_b;
    logic [SAMPLE_BITS-1:0] held_peak_a;
    round_ev_t              ev;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= SAMPLE_BITS'(LOW_RESET);
            high_reg <= SAMPLE_BITS'(HIGH_RESET);
            rate_reg <= RATE_BITS'(RATE_RESET);
            vref_reg <= VREF_BITS'(VREF_RESET);
        end
        else if (wr)
        begin
            case (idx)
                REG_LOW_LEVEL:  low_reg  <= pwdata[SAMPLE_BITS-1:0];
                REG_HIGH_LEVEL: high_reg <= pwdata[SAMPLE_BITS-1:0];
                REG_TIMER_RATE: rate_reg <= pwdata[RATE_BITS-1:0];
                REG_VREF:       vref_reg <= pwdata[VREF_BITS-1:0];
                default:        vref_reg <= vref_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LOW_LEVEL:  prdata = APB_DATA_BITS'(low_reg);
            REG_HIGH_LEVEL: prdata = APB_DATA_BITS'(high_reg);
            REG_TIMER_RATE: prdata = APB_DATA_BITS'(rate_reg);
            REG_VREF:       prdata = APB_DATA_BITS'(vref_reg);
            default:        prdata = '0;
        endcase
    end

    assign samples.ready = !busy;
    assign take          = samples.valid && !busy;

    tcpam_seq #(.CNT_W(COUNT_BITS)) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .sample_a    (samples.sample_a),
        .sample_b    (samples.sample_b),
        .elapsed     (samples.elapsed_ticks),
        .low_level   (low_reg),
        .high_level  (high_reg),
        .delay_ticks (delay_ticks),
        .half_a      (half_a),
        .half_b      (half_b),
        .held_peak_a (held_peak_a),
        .ev          (ev)
    );

    tcpam_calc #(.CNT_W(COUNT_BITS)) u_calc (
        .clk           (clk),
        .rst_n         (rst_n),
        .ev            (ev),
        .delay_ticks   (delay_ticks),
        .half_a        (half_a),
        .half_b        (half_b),
        .peak_a        (held_peak_a),
        .peak_b        (samples.sample_b),
        .timer_rate_hz (rate_reg),
        .vref_mv       (vref_reg),
        .busy          (busy),
        .res           (results)
    );
endmodule
`default_nettype wire

// ===== tb/two_channel_phase_amplitude_meter_tb.sv =====
// Self-checking testbench for the two-channel phase and amplitude meter.
`timescale 1ns / 1ps
module two_channel_phase_amplitude_meter_tb;
    import tcpam_pkg::*;

    localparam longint COUNT_MAX = (64'd1 << 32) - 1;
    localparam longint WIDE_MAX  = (64'd1 << 33) - 1;
    localparam longint RMS_DIV   = 1023 * 1414;
    localparam int     SETTLE_CYCLES = 400;

    typedef struct {
        logic [32:0] period_a;
        logic [32:0] period_b;
        logic [32:0] freq_a;
        logic [9:0]  peak_a;
        logic [9:0]  peak_b;
        logic [11:0] rms_a;
        logic [11:0] rms_b;
        logic [15:0] phase;
        logic        zero_period;
    } meter_result_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic pready;

    tcpam_in_if  samples_if ();
    tcpam_out_if results_if ();

    two_channel_phase_amplitude_meter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples_if),
        .results (results_if)
    );

    // predictor copy of the register file and sequencer
    logic [9:0]  cfg_low, cfg_high;
    logic [26:0] cfg_rate;
    logic [12:0] cfg_vref;
    logic [3:0]  seq_step;
    longint      tick_count, delay_ticks, half_a, half_b;
    logic [9:0]  held_peak_a;

    meter_result_t pending_results[$];
    int fail_count;
    int words_sent;
    int results_seen;
    int hold_left;
    bit no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Timeout at %0t", $time);
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint rms_of(longint peak);
        longint r;
        r = (peak * cfg_vref * 1000) / RMS_DIV;
        return (r > 4095) ? 4095 : r;
    endfunction

    function automatic longint double_sat(longint h);
        return (h * 2 > WIDE_MAX) ? WIDE_MAX : h * 2;
    endfunction

    function automatic void count_ticks(longint e);
        tick_count = (tick_count + e > COUNT_MAX) ? COUNT_MAX : tick_count + e;
    endfunction

    function automatic void predict_word(logic [9:0] a, logic [9:0] b, logic [15:0] e);
        bit a_low, a_high, b_low, b_high;
        longint p, freq;
        meter_result_t r;
        a_low  = a <= cfg_low;
        a_high = a >= cfg_high;
        b_low  = b <= cfg_low;
        b_high = b >= cfg_high;
        case (seq_step)
            4'd0, 4'd4, 4'd7: if (a_low) seq_step++;
            4'd1, 4'd5, 4'd8, 4'd11, 4'd14:
            begin
                if ((seq_step == 4'd11 || seq_step == 4'd14) ? b_high : a_high)
                begin
                    tick_count = 0;
                    seq_step++;
                end
            end
            4'd2:
            begin
                count_ticks(e);
                if (b_low) seq_step++;
            end
            4'd3:
            begin
                count_ticks(e);
                if (b_high)
                begin
                    delay_ticks = tick_count;
                    seq_step++;
                end
            end
            4'd6:
            begin
                count_ticks(e);
                if (a_low)
                begin
                    half_a = tick_count;
                    seq_step++;
                end
            end
            4'd9:
            begin
                count_ticks(e);
                if (tick_count * 2 >= half_a)
                begin
                    held_peak_a = a;
                    seq_step++;
                end
            end
            4'd10, 4'd13: if (b_low) seq_step++;
            4'd12:
            begin
                count_ticks(e);
                if (b_low)
                begin
                    half_b = tick_count;
                    seq_step++;
                end
            end
            default:
            begin
                count_ticks(e);
                if (tick_count * 2 >= half_b)
                begin
                    seq_step = 4'd0;
                    p = 0;
                    freq = 0;
                    if (half_a != 0)
                    begin
                        p = (delay_ticks * 18000) / half_a;
                        if (p > 35999) p = 35999;
                        // wrap to negative, then lag corrections
                        if (p > 18000)
                        begin
                            p -= 36000;
                            if (p < -2000) p -= 500;
                            else if (p > -2000 && p < 0) p -= 300;
                        end
                        freq = (cfg_rate * 64'd100) / (half_a * 2);
                        if (freq > WIDE_MAX) freq = WIDE_MAX;
                    end
                    r.period_a    = double_sat(half_a);
                    r.period_b    = double_sat(half_b);
                    r.freq_a      = freq;
                    r.peak_a      = held_peak_a;
                    r.peak_b      = b;
                    r.rms_a       = rms_of(held_peak_a);
                    r.rms_b       = rms_of(b);
                    r.phase       = p[15:0];
                    r.zero_period = (half_a == 0);
                    pending_results.push_back(r);
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result word", $time);
                fail_count++;
            end
            else
            begin
                meter_result_t r;
                r = pending_results.pop_front();
                check_field("period_a", r.period_a, results_if.period_a_ticks);
                check_field("period_b", r.period_b, results_if.period_b_ticks);
                check_field("freq_a", r.freq_a, results_if.freq_a_centihz);
                check_field("peak_a", r.peak_a, results_if.peak_a);
                check_field("peak_b", r.peak_b, results_if.peak_b);
                check_field("rms_a", r.rms_a, results_if.rms_a_mv);
                check_field("rms_b", r.rms_b, results_if.rms_b_mv);
                check_field("phase", $signed(r.phase), results_if.phase_centideg);
                check_field("zero_period", r.zero_period, results_if.zero_period);
            end
        end
    end

    // result receiver: random stalls plus a long hold when requested
    initial
    begin
        int stall_left;
        stall_left = 0;
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                results_if.ready <= 1'b0;
            end
            else
            begin
                if (!no_gaps && $urandom_range(0, 99) < 15)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                             : $urandom_range(1, 4);
                results_if.ready <= (stall_left == 0);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_word(logic [9:0] a, logic [9:0] b, logic [15:0] e);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            samples_if.valid <= 1'b0;
        end
        @(negedge clk);
        samples_if.valid         <= 1'b1;
        samples_if.sample_a      <= a;
        samples_if.sample_b      <= b;
        samples_if.elapsed_ticks <= e;
        do @(posedge clk); while (!samples_if.ready);
        predict_word(a, b, e);
        words_sent++;
    endtask

    // wait out every expected word and any round still in the engine
    task automatic drain();
        @(negedge clk);
        samples_if.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'(idx) << 2;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_LOW_LEVEL:  cfg_low  = value[9:0];
            REG_HIGH_LEVEL: cfg_high = value[9:0];
            REG_TIMER_RATE: cfg_rate = value[26:0];
            default:        cfg_vref = value[12:0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_check(reg_idx_t idx, logic [31:0] exp_v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_BITS'(idx) << 2;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        check_field("register read", exp_v, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_config(logic [9:0] lo, logic [9:0] hi, logic [26:0] rate,
                                logic [12:0] vref);
        apb_write(REG_LOW_LEVEL, lo);
        apb_write(REG_HIGH_LEVEL, hi);
        apb_write(REG_TIMER_RATE, rate);
        apb_write(REG_VREF, vref);
    endtask

    // one full sequencer round with exact tick counts; needs low < high
    task automatic send_round(int delay, int ha, int hb, logic [9:0] pk_a, logic [9:0] pk_b);
        logic [9:0] lo, hi;
        lo = 10'd0;
        hi = 10'h3FF;
        send_word(lo, hi, 16'd7);       // A low
        send_word(hi, hi, 16'd9);       // A rise, start delay count
        send_word(hi, lo, delay);       // B low
        send_word(hi, hi, 16'd0);       // B rise ends delay
        send_word(lo, hi, 16'd3);
        send_word(hi, lo, 16'd5);       // A rise, start half period
        send_word(lo, lo, ha);          // A falls
        send_word(lo, hi, 16'd2);
        send_word(hi, hi, 16'd4);       // A rise
        send_word(pk_a, lo, ha);        // quarter period reached: peak A
        send_word(hi, lo, 16'd1);
        send_word(lo, hi, 16'd6);       // B rise
        send_word(hi, lo, hb);          // B falls
        send_word(hi, lo, 16'd8);
        send_word(lo, hi, 16'd3);       // B rise
        send_word(lo, pk_b, hb);        // peak B, round ends
    endtask

    // periodic two-channel signal with random levels, ticks and some noise
    task automatic send_wave(int n_words);
        int period, shift, tick_max;
        logic [9:0] a, b;
        period = $urandom_range(2, 24);
        shift = $urandom_range(0, period - 1);
        tick_max = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 60);
        for (int k = 0; k < n_words; k++)
        begin
            a = ((k % period) < period / 2) ? $urandom_range(cfg_high, 1023)
                                            : $urandom_range(0, cfg_low);
            b = (((k + shift) % period) < period / 2) ? $urandom_range(cfg_high, 1023)
                                                      : $urandom_range(0, cfg_low);
            if ($urandom_range(0, 99) < 8)
            begin
                a = $urandom;
                b = $urandom;
            end
            send_word(a, b, $urandom_range(0, tick_max));
        end
    endtask

    task automatic test_register_reset();
        apb_check(REG_LOW_LEVEL, LOW_RESET);
        apb_check(REG_HIGH_LEVEL, HIGH_RESET);
        apb_check(REG_TIMER_RATE, RATE_RESET);
        apb_check(REG_VREF, VREF_RESET);
    endtask

    task automatic test_phase_corners();
        send_round(100, 100, 50, 10'h3FF, 10'h000);  // exactly half turn
        send_round(189, 100, 50, 10'h000, 10'h3FF);  // small lag correction
        send_round(17, 9, 9, 10'h155, 10'h2AA);      // exactly -20 deg
        send_round(150, 100, 65535, 10'h2AA, 10'h155); // large lag correction
        send_round(300, 100, 0, 10'h3FF, 10'h3FF);   // clamp
        drain();
    endtask

    task automatic test_zero_period();
        send_round(40, 0, 12, 10'h200, 10'h1FF);
        drain();
    endtask

    task automatic test_config_extremes();
        write_config(10'd0, 10'd1023, 27'd1, 13'd1);
        send_round(25, 65535, 3, 10'h3FF, 10'h3FF);
        send_wave(60);
        drain();
        write_config(10'd1023, 10'd0, 27'd100000000, 13'd5000);
        send_wave(40);                              // every sample both low and high
        drain();
        write_config(10'd0, 10'd1023, 27'd100000000, 13'd5000);
        send_round(1, 1, 1, 10'h3FF, 10'h3FF);
        drain();
    endtask

    task automatic test_backpressure();
        hold_left = 800;
        no_gaps = 1'b1;
        send_wave(200);
        no_gaps = 1'b0;
        drain();
    endtask

    task automatic test_random();
        int lo;
        while (words_sent < 1450)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                drain();
                lo = $urandom_range(0, 600);
                write_config(lo, $urandom_range(lo + 1, 1023), $urandom_range(1, 100000000),
                             $urandom_range(1, 5000));
            end
            no_gaps = ($urandom_range(0, 4) == 0);
            send_wave($urandom_range(20, 120));
        end
        no_gaps = 1'b0;
        drain();
    endtask

    initial
    begin
        fail_count = 0;
        words_sent = 0;
        results_seen = 0;
        hold_left = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        samples_if.valid = 1'b0;
        samples_if.sample_a = '0;
        samples_if.sample_b = '0;
        samples_if.elapsed_ticks = '0;
        cfg_low = LOW_RESET;
        cfg_high = HIGH_RESET;
        cfg_rate = RATE_RESET;
        cfg_vref = VREF_RESET;
        seq_step = 4'd0;
        tick_count = 0;
        delay_ticks = 0;
        half_a = 0;
        half_b = 0;
        held_peak_a = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_reset();
        test_phase_corners();
        test_zero_period();
        test_config_extremes();
        test_backpressure();
        test_random();

        if (pending_results.size() != 0)
        begin
            $display("%0t %0d expected words never arrived", $time, pending_results.size());
            fail_count++;
        end
        $display("Sent %0d sample words, checked %0d result words", words_sent, results_seen);
        $display("Covered phase corners, zero period, threshold extremes and backpressure");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
